[hw/rtl/rmn_pkg.sv]
// Package for the rational multiply and normalize unit.
// Holds the word width, opcodes, transaction payload types, FSM states and unit status.
// Used by every module in hw/rtl; depends on nothing.
package rmn_pkg;

  localparam int unsigned WIDTH   = 32;
  localparam int unsigned FIELD_W = 32;

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam logic [1:0] OP_NORMALIZE = 2'd0;
  localparam logic [1:0] OP_EXTEND    = 2'd1;
  localparam logic [1:0] OP_PRODUCT   = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic       x_sign;
    field_t     x_num;
    field_t     x_den;
    logic       y_sign;
    field_t     y_num;
    field_t     y_den;
    field_t     factor;
  } in_t;

  typedef struct packed {
    logic   res_sign;
    field_t res_num;
    field_t res_den;
    logic   zero_gcd_error;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

[hw/rtl/rmn_mul.sv]
// Bit-serial shift-and-add multiplier, product modulo 2^WIDTH.
// Retires one multiplier bit per cycle.
// Depends on rmn_pkg.
module rmn_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rmn_pkg::word_t    op_a,
  input  rmn_pkg::word_t    op_b,
  output rmn_pkg::word_t    prod,
  output rmn_pkg::unit_sts_t sts
);

  localparam int unsigned CNT_W = (rmn_pkg::WIDTH > 1) ? $clog2(rmn_pkg::WIDTH) : 1;

  rmn_pkg::word_t     a_r;
  rmn_pkg::word_t     b_r;
  rmn_pkg::word_t     acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
      cnt_r <= CNT_W'(rmn_pkg::WIDTH - 1);
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign prod     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[hw/rtl/rmn_gcd.sv]
// Binary greatest common divisor unit, one reduction step per cycle.
// The gcd of zero and zero is zero.
// Depends on rmn_pkg.
module rmn_gcd (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rmn_pkg::word_t     op_a,
  input  rmn_pkg::word_t     op_b,
  output rmn_pkg::word_t     gcd,
  output rmn_pkg::unit_sts_t sts
);

  localparam int unsigned K_W = (rmn_pkg::WIDTH > 1) ? $clog2(rmn_pkg::WIDTH) : 1;

  rmn_pkg::word_t   a_r;
  rmn_pkg::word_t   b_r;
  rmn_pkg::word_t   g_r;
  logic [K_W-1:0]   k_r;
  logic             busy_r;
  logic             done_r;
  logic             finish;

  assign finish = busy_r && ((a_r == '0) || (b_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= finish;
      if (start) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
      k_r <= '0;
    end else if (busy_r) begin
      if (a_r == '0) begin
        g_r <= b_r << k_r;
      end else if (b_r == '0) begin
        g_r <= a_r << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

  assign gcd      = g_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[hw/rtl/rmn_div.sv]
// Restoring divider producing one quotient bit per cycle.
// The divisor must be nonzero; the remainder is discarded.
// Depends on rmn_pkg.
module rmn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rmn_pkg::word_t     dividend,
  input  rmn_pkg::word_t     divisor,
  output rmn_pkg::word_t     quot,
  output rmn_pkg::unit_sts_t sts
);

  localparam int unsigned W     = rmn_pkg::WIDTH;
  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

  rmn_pkg::word_t   q_r;
  rmn_pkg::word_t   rem_r;
  rmn_pkg::word_t   d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       trial;
  logic [W:0]       diff;

  assign trial = {rem_r, q_r[W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= CNT_W'(W - 1);
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[hw/rtl/rational_multiply_normalize.sv]
// Top level of the rational multiply and normalize unit.
// Sequences two serial multipliers, a binary gcd unit and two serial dividers.
// Depends on rmn_pkg, rmn_mul, rmn_gcd and rmn_div.
//
// Usage: one input transaction on in_valid/in_stall/in_data yields exactly one
// result transaction on out_valid/out_stall/out_data. The unit works on one
// transaction at a time and holds in_stall high from acceptance until the result
// has moved into the output register.
// Extend runs the two bit-serial multipliers and returns their products.
// Normalize runs the gcd unit on the first operand, then the two dividers.
// Product runs the multipliers first and then normalizes the products.
// When both parts are zero the divide phase is skipped and the error flag is set.
// Opcode 3 returns the first operand unchanged.
// The output register lets the next transaction be accepted while a result still
// waits; a stalled result holds until taken, and the unit then waits to load the
// next one. Reset is synchronous and clears all control state and out_valid.
module rational_multiply_normalize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmn_pkg::out_t out_data
);

  rmn_pkg::state_t    state_r;
  rmn_pkg::state_t    state_nxt;

  logic [1:0]         op_r;
  logic               sign_r;
  rmn_pkg::word_t     num_r;
  rmn_pkg::word_t     den_r;
  logic               err_r;
  logic               out_valid_r;
  rmn_pkg::out_t      out_data_r;

  logic               in_acc;
  logic               mul_start;
  logic               gcd_start;
  logic               div_start;
  logic               out_load;

  rmn_pkg::word_t     in_xn;
  rmn_pkg::word_t     in_xd;
  rmn_pkg::word_t     mul_b_n;
  rmn_pkg::word_t     mul_b_d;
  rmn_pkg::word_t     prod_n;
  rmn_pkg::word_t     prod_d;
  rmn_pkg::word_t     gcd_a;
  rmn_pkg::word_t     gcd_b;
  rmn_pkg::word_t     gcd_g;
  rmn_pkg::word_t     quot_n;
  rmn_pkg::word_t     quot_d;
  rmn_pkg::unit_sts_t mul_n_sts;
  rmn_pkg::unit_sts_t mul_d_sts;
  rmn_pkg::unit_sts_t gcd_sts;
  rmn_pkg::unit_sts_t div_n_sts;
  rmn_pkg::unit_sts_t div_d_sts;

  assign in_xn = rmn_pkg::WIDTH'(in_data.x_num);
  assign in_xd = rmn_pkg::WIDTH'(in_data.x_den);

  always_comb begin
    if (in_data.opcode == rmn_pkg::OP_EXTEND) begin
      mul_b_n = rmn_pkg::WIDTH'(in_data.factor);
      mul_b_d = rmn_pkg::WIDTH'(in_data.factor);
    end else begin
      mul_b_n = rmn_pkg::WIDTH'(in_data.y_num);
      mul_b_d = rmn_pkg::WIDTH'(in_data.y_den);
    end
  end

  assign gcd_a = (state_r == rmn_pkg::ST_IDLE) ? in_xn : prod_n;
  assign gcd_b = (state_r == rmn_pkg::ST_IDLE) ? in_xd : prod_d;

  rmn_mul u_mul_n (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (in_xn),
    .op_b  (mul_b_n),
    .prod  (prod_n),
    .sts   (mul_n_sts)
  );

  rmn_mul u_mul_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (in_xd),
    .op_b  (mul_b_d),
    .prod  (prod_d),
    .sts   (mul_d_sts)
  );

  rmn_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .op_a  (gcd_a),
    .op_b  (gcd_b),
    .gcd   (gcd_g),
    .sts   (gcd_sts)
  );

  rmn_div u_div_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (gcd_g),
    .quot     (quot_n),
    .sts      (div_n_sts)
  );

  rmn_div u_div_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (den_r),
    .divisor  (gcd_g),
    .quot     (quot_d),
    .sts      (div_d_sts)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmn_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == rmn_pkg::OP_NORMALIZE) begin
            state_nxt = rmn_pkg::ST_GCD;
          end else if ((in_data.opcode == rmn_pkg::OP_EXTEND) ||
                       (in_data.opcode == rmn_pkg::OP_PRODUCT)) begin
            state_nxt = rmn_pkg::ST_MUL;
          end else begin
            state_nxt = rmn_pkg::ST_HOLD;
          end
        end
      end
      rmn_pkg::ST_MUL: begin
        if (mul_n_sts.done) begin
          state_nxt = (op_r == rmn_pkg::OP_PRODUCT) ? rmn_pkg::ST_GCD : rmn_pkg::ST_HOLD;
        end
      end
      rmn_pkg::ST_GCD: begin
        if (gcd_sts.done) begin
          state_nxt = (gcd_g == '0) ? rmn_pkg::ST_HOLD : rmn_pkg::ST_DIV;
        end
      end
      rmn_pkg::ST_DIV: begin
        if (div_n_sts.done) begin
          state_nxt = rmn_pkg::ST_HOLD;
        end
      end
      rmn_pkg::ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = rmn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    gcd_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      rmn_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        mul_start = in_valid && ((in_data.opcode == rmn_pkg::OP_EXTEND) ||
                                 (in_data.opcode == rmn_pkg::OP_PRODUCT));
        gcd_start = in_valid && (in_data.opcode == rmn_pkg::OP_NORMALIZE);
      end
      rmn_pkg::ST_MUL: begin
        gcd_start = mul_n_sts.done && (op_r == rmn_pkg::OP_PRODUCT);
      end
      rmn_pkg::ST_GCD: begin
        div_start = gcd_sts.done && (gcd_g != '0);
      end
      rmn_pkg::ST_DIV: begin
      end
      rmn_pkg::ST_HOLD: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.opcode;
      sign_r <= (in_data.opcode == rmn_pkg::OP_PRODUCT) ? (in_data.x_sign ^ in_data.y_sign)
                                                        : in_data.x_sign;
      num_r  <= in_xn;
      den_r  <= in_xd;
      err_r  <= 1'b0;
    end else if ((state_r == rmn_pkg::ST_MUL) && mul_n_sts.done) begin
      num_r <= prod_n;
      den_r <= prod_d;
    end else if ((state_r == rmn_pkg::ST_GCD) && gcd_sts.done && (gcd_g == '0)) begin
      err_r <= 1'b1;
    end else if ((state_r == rmn_pkg::ST_DIV) && div_n_sts.done) begin
      num_r <= quot_n;
      den_r <= quot_d;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.res_sign       <= sign_r;
      out_data_r.res_num        <= rmn_pkg::FIELD_W'(num_r);
      out_data_r.res_den        <= rmn_pkg::FIELD_W'(den_r);
      out_data_r.zero_gcd_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmn_pkg::ST_IDLE) |-> !mul_n_sts.busy && !mul_d_sts.busy &&
      !gcd_sts.busy && !div_n_sts.busy && !div_d_sts.busy)
    else $error("arithmetic unit busy while the controller is idle");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_n_sts.done == mul_d_sts.done) && (div_n_sts.done == div_d_sts.done))
    else $error("paired serial units out of step");

  a_done_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (!gcd_sts.done || (state_r == rmn_pkg::ST_GCD)) &&
    (!div_n_sts.done || (state_r == rmn_pkg::ST_DIV)))
    else $error("unit finished outside its phase");

  a_err_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zero_gcd_error) |->
      (out_data_r.res_num == '0) && (out_data_r.res_den == '0))
    else $error("error flagged on a result that is not zero over zero");

  a_load_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (state_r == rmn_pkg::ST_IDLE))
    else $error("output load did not return the controller to idle");

endmodule
